FILE: rtl/i2c_rts_pkg.sv
// package for the i2c register transfer sequencer
// holds request/result structs, phase and command codes, buffer sizing helpers
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package i2c_rts_pkg;

  localparam int BUF_DEPTH = 32;
  localparam int PTR_W     = $clog2(BUF_DEPTH);

  typedef logic [PTR_W-1:0] ptr_t;

  localparam logic [2:0] REQ_START  = 3'd0;
  localparam logic [2:0] REQ_LOAD   = 3'd1;
  localparam logic [2:0] REQ_POLL   = 3'd2;
  localparam logic [2:0] REQ_STOP   = 3'd3;
  localparam logic [2:0] REQ_ACCESS = 3'd4;
  localparam logic [2:0] REQ_TX     = 3'd5;
  localparam logic [2:0] REQ_RX     = 3'd6;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_WR_PEND = 3'd1;
  localparam logic [2:0] PH_WR_BUSY = 3'd2;
  localparam logic [2:0] PH_AD_PEND = 3'd3;
  localparam logic [2:0] PH_AD_BUSY = 3'd4;
  localparam logic [2:0] PH_RD_PEND = 3'd5;
  localparam logic [2:0] PH_RD_BUSY = 3'd6;

  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_ADDR  = 3'd2;
  localparam logic [2:0] CMD_READ  = 3'd3;
  localparam logic [2:0] CMD_STOP  = 3'd4;

  localparam logic [3:0] RETRY_LIMIT_RST = 4'd3;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_START,
    OP_LOAD,
    OP_POLL,
    OP_STOP,
    OP_ACCESS,
    OP_TX,
    OP_RX
  } op_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [9:0]  dev_addr;
    logic [15:0] reg_addr;
    logic        long_addr;
    logic [5:0]  msg_len;
    logic        is_read;
    logic [4:0]  buf_index;
    logic [7:0]  data_byte;
    logic        stop_pending;
    logic        bus_busy;
    logic        nack;
  } req_t;

  typedef struct packed {
    logic [2:0] msg_state;
    logic [2:0] command;
    logic [5:0] byte_count;
    logic [9:0] target_addr;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [4:0] buf_pos;
    logic [3:0] retry_count;
    logic [3:0] nack_count;
    logic       aborted;
  } rsp_t;

  typedef struct packed {
    op_e         op;
    logic [9:0]  dev_addr;
    logic [15:0] reg_addr;
    logic        long_addr;
    logic [5:0]  msg_len;
    logic        is_read;
    ptr_t        slot;
    logic [7:0]  data_byte;
    logic        stop_pending;
    logic        bus_busy;
    logic        nack;
  } op_t;

  // slot index reduced into the buffer depth
  function automatic ptr_t buf_slot(logic [4:0] idx);
    logic [8:0] v;
    v = 9'(idx);
    for (int i = 0; i < 8; i++) begin
      if (v >= 9'(BUF_DEPTH)) begin
        v = v - 9'(BUF_DEPTH);
      end
    end
    return v[PTR_W-1:0];
  endfunction

  function automatic ptr_t ptr_next(ptr_t p);
    ptr_t n;
    if (p == PTR_W'(BUF_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + PTR_W'(1);
    end
    return n;
  endfunction

  function automatic logic [4:0] pos_of(ptr_t p);
    logic [8:0] e;
    e = 9'(p);
    return e[4:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/i2c_rts_front.sv
// front end: accepts requests, classifies them and holds them in a two-entry queue
// depends on i2c_rts_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2c_rts_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push,
  output logic                full,
  input  i2c_rts_pkg::req_t   req_i,
  input  wire                 take_i,
  output logic                head_valid_o,
  output i2c_rts_pkg::op_t    head_o
);
  import i2c_rts_pkg::*;

  op_t        mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  op_t        dec;
  logic       wr_en;

  always_comb begin
    dec              = '0;
    dec.dev_addr     = req_i.dev_addr;
    dec.reg_addr     = req_i.reg_addr;
    dec.long_addr    = req_i.long_addr;
    dec.msg_len      = req_i.msg_len;
    dec.is_read      = req_i.is_read;
    dec.slot         = buf_slot(req_i.buf_index);
    dec.data_byte    = req_i.data_byte;
    dec.stop_pending = req_i.stop_pending;
    dec.bus_busy     = req_i.bus_busy;
    dec.nack         = req_i.nack;
    case (req_i.req_type)
      REQ_START:  dec.op = OP_START;
      REQ_LOAD:   dec.op = OP_LOAD;
      REQ_POLL:   dec.op = OP_POLL;
      REQ_STOP:   dec.op = OP_STOP;
      REQ_ACCESS: dec.op = OP_ACCESS;
      REQ_TX:     dec.op = OP_TX;
      REQ_RX:     dec.op = OP_RX;
      default:    dec.op = OP_NONE;
    endcase
  end

  assign full         = (cnt_q == 2'd2);
  assign wr_en        = push && !full;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_q <= !wr_q;
      end
      if (take_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(wr_en) - 2'(take_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= dec;
    end
  end

  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && !take_i |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("front queue count did not advance");

  a_take_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i |-> cnt_q != 2'd0)
    else $error("request taken from empty front queue");

endmodule

`default_nettype wire

FILE: rtl/i2c_rts_back.sv
// back end: message state, write buffer, retry counters and the result queue
// depends on i2c_rts_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2c_rts_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire  [3:0]          cfg_wdata_i,
  input  wire                 head_valid_i,
  input  i2c_rts_pkg::op_t    head_i,
  output logic                take_o,
  output logic                empty,
  input  wire                 pop,
  output i2c_rts_pkg::rsp_t   rsp_o
);
  import i2c_rts_pkg::*;

  logic [3:0]  limit_q;
  logic [2:0]  phase_q, phase_d;
  logic [9:0]  dev_q, dev_d;
  logic [15:0] reg_q, reg_d;
  logic        hbp_q, hbp_d;
  logic [5:0]  len_q, len_d;
  ptr_t        ptr_q, ptr_d;
  logic [3:0]  att_q, att_d;
  logic [3:0]  nack_q, nack_d;
  logic [7:0]  store_q [BUF_DEPTH];

  logic        st_we;
  ptr_t        st_addr;
  logic [7:0]  st_data;
  logic        fail, abort;
  logic [7:0]  first_byte;
  logic [6:0]  wr_cnt;
  logic [3:0]  att_inc, nack_inc;
  rsp_t        res;

  rsp_t        out_q [2];
  logic        out_wr_q, out_rd_q;
  logic [1:0]  out_cnt_q;
  logic        out_pop;

  assign out_pop = pop && !empty;
  assign take_o  = head_valid_i && ((out_cnt_q != 2'd2) || out_pop);
  assign empty   = (out_cnt_q == 2'd0);
  assign rsp_o   = out_q[out_rd_q];

  always_comb begin
    phase_d    = phase_q;
    dev_d      = dev_q;
    reg_d      = reg_q;
    hbp_d      = hbp_q;
    len_d      = len_q;
    ptr_d      = ptr_q;
    att_d      = att_q;
    nack_d     = nack_q;
    st_we      = 1'b0;
    st_addr    = ptr_q;
    st_data    = head_i.data_byte;
    fail       = 1'b0;
    abort      = 1'b0;
    res        = '0;
    first_byte = hbp_q ? reg_q[15:8] : reg_q[7:0];
    wr_cnt     = 7'(len_q) + (hbp_q ? 7'd2 : 7'd1);
    att_inc    = att_q + 4'd1;
    nack_inc   = nack_q + 4'd1;
    case (head_i.op)
      OP_START: begin
        dev_d   = head_i.dev_addr;
        reg_d   = head_i.reg_addr;
        hbp_d   = head_i.long_addr;
        len_d   = head_i.msg_len;
        phase_d = head_i.is_read ? PH_AD_PEND : PH_WR_PEND;
        ptr_d   = '0;
        att_d   = '0;
      end
      OP_LOAD: begin
        st_we   = 1'b1;
        st_addr = head_i.slot;
      end
      OP_POLL: begin
        case (phase_q)
          PH_WR_PEND: begin
            if (!head_i.stop_pending && !head_i.bus_busy) begin
              res.command     = CMD_WRITE;
              res.target_addr = dev_q;
              res.byte_count  = (wr_cnt > 7'd63) ? 6'd63 : wr_cnt[5:0];
              res.tx_valid    = 1'b1;
              res.tx_byte     = first_byte;
              phase_d         = PH_WR_BUSY;
            end
          end
          PH_AD_PEND: begin
            if (!head_i.stop_pending && !head_i.bus_busy) begin
              res.command     = CMD_ADDR;
              res.target_addr = dev_q;
              res.byte_count  = hbp_q ? 6'd2 : 6'd1;
              res.tx_valid    = 1'b1;
              res.tx_byte     = first_byte;
              phase_d         = PH_AD_BUSY;
            end else begin
              fail = 1'b1;
            end
          end
          PH_RD_PEND: begin
            if (!head_i.stop_pending) begin
              res.command     = CMD_READ;
              res.target_addr = dev_q;
              res.byte_count  = len_q;
              phase_d         = PH_RD_BUSY;
            end else begin
              fail = 1'b1;
            end
          end
          default: ;
        endcase
        if (fail) begin
          att_d = att_inc;
          abort = (att_inc >= limit_q);
        end
      end
      OP_STOP: begin
        nack_d = '0;
        if (phase_q == PH_WR_BUSY || phase_q == PH_RD_BUSY) begin
          phase_d = PH_IDLE;
        end else if (phase_q == PH_AD_BUSY) begin
          phase_d = PH_AD_PEND;
        end
      end
      OP_ACCESS: begin
        if (head_i.nack) begin
          res.command     = CMD_STOP;
          res.target_addr = dev_q;
          nack_d          = nack_inc;
          abort           = (nack_inc >= limit_q);
        end else if (phase_q == PH_AD_BUSY) begin
          phase_d = PH_RD_PEND;
        end
      end
      OP_TX: begin
        res.tx_valid = 1'b1;
        if (hbp_q) begin
          res.tx_byte = reg_q[7:0];
          hbp_d       = 1'b0;
        end else begin
          res.tx_byte = store_q[ptr_q];
          ptr_d       = ptr_next(ptr_q);
        end
      end
      OP_RX: begin
        st_we        = 1'b1;
        ptr_d        = ptr_next(ptr_q);
        res.rx_valid = 1'b1;
        res.rx_byte  = head_i.data_byte;
      end
      default: ;
    endcase
    if (abort) begin
      phase_d     = PH_IDLE;
      dev_d       = '0;
      reg_d       = '0;
      hbp_d       = 1'b0;
      len_d       = '0;
      ptr_d       = '0;
      att_d       = '0;
      nack_d      = '0;
      res.aborted = 1'b1;
    end
    res.msg_state   = phase_d;
    res.buf_pos     = pos_of(ptr_d);
    res.retry_count = att_d;
    res.nack_count  = nack_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= RETRY_LIMIT_RST;
      phase_q <= PH_IDLE;
      dev_q   <= '0;
      reg_q   <= '0;
      hbp_q   <= 1'b0;
      len_q   <= '0;
      ptr_q   <= '0;
      att_q   <= '0;
      nack_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (take_o) begin
        phase_q <= phase_d;
        dev_q   <= dev_d;
        reg_q   <= reg_d;
        hbp_q   <= hbp_d;
        len_q   <= len_d;
        ptr_q   <= ptr_d;
        att_q   <= att_d;
        nack_q  <= nack_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUF_DEPTH; i++) begin
        store_q[i] <= '0;
      end
    end else if (take_o && abort) begin
      for (int i = 0; i < BUF_DEPTH; i++) begin
        store_q[i] <= '0;
      end
    end else if (take_o && st_we) begin
      store_q[st_addr] <= st_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= 1'b0;
      out_rd_q  <= 1'b0;
      out_cnt_q <= 2'd0;
    end else begin
      if (take_o) begin
        out_wr_q <= !out_wr_q;
      end
      if (out_pop) begin
        out_rd_q <= !out_rd_q;
      end
      out_cnt_q <= out_cnt_q + 2'(take_o) - 2'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      out_q[out_wr_q] <= res;
    end
  end

  a_abort_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && abort |=> phase_q == PH_IDLE && ptr_q == '0 && att_q == '0 && nack_q == '0)
    else $error("abort left message state behind");

  a_no_cmd_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && res.command == CMD_NONE |-> res.byte_count == '0 && res.target_addr == '0)
    else $error("byte count or target without command");

  a_result_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |=> !empty)
    else $error("executed request produced no visible result");

endmodule

`default_nettype wire

FILE: rtl/i2c_register_transfer_sequencer.sv
// channel   | handshake             | payload
// request   | push / full           | req_i  (i2c_rts_pkg::req_t)
// result    | empty / pop           | rsp_o  (i2c_rts_pkg::rsp_t)
// config    | cfg_we_i              | cfg_wdata_i (retry limit, 4 bits)
//
// one request per cycle sustained while results are popped, one result per request
// an accepted request waits in the front queue; its result is registered into the result queue and shown on rsp_o
// front queue (2 entries) and result queue (2 entries) let each side stall alone
// async active-low reset: idle phase, empty buffer, retry limit 3
// top level, depends on i2c_rts_pkg, i2c_rts_front, i2c_rts_back
`timescale 1ns / 1ps
`default_nettype none

module i2c_register_transfer_sequencer (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push,
  output logic                full,
  input  i2c_rts_pkg::req_t   req_i,
  output logic                empty,
  input  wire                 pop,
  output i2c_rts_pkg::rsp_t   rsp_o,
  input  wire                 cfg_we_i,
  input  wire  [3:0]          cfg_wdata_i
);
  import i2c_rts_pkg::*;

  logic head_valid;
  logic take;
  op_t  head;

  i2c_rts_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .req_i        (req_i),
    .take_i       (take),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  i2c_rts_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .head_valid_i (head_valid),
    .head_i       (head),
    .take_o       (take),
    .empty        (empty),
    .pop          (pop),
    .rsp_o        (rsp_o)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb_i2c_register_transfer_sequencer.sv
// self-checking testbench for i2c_register_transfer_sequencer: directed and random
// bus events through the request queue, outputs checked against a built-in predictor
// depends on i2c_rts_pkg and the sequencer rtl
`timescale 1ns / 1ps

module tb_i2c_register_transfer_sequencer;
  import i2c_rts_pkg::*;

  localparam logic [2:0] REQ_UNUSED = 3'd7;

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  req_t       req_i;
  logic       empty;
  logic       pop;
  rsp_t       rsp_o;
  logic       cfg_we_i;
  logic [3:0] cfg_wdata_i;

  i2c_register_transfer_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_i       (req_i),
    .empty       (empty),
    .pop         (pop),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [3:0]  retry_limit_q;
  logic [2:0]  phase_q;
  logic [9:0]  dev_q;
  logic [15:0] reg_q;
  logic        hi_pend_q;
  logic [5:0]  len_q;
  logic [7:0]  store_q [0:31];
  logic [4:0]  ptr_q;
  logic [3:0]  attempts_q;
  logic [3:0]  nacks_q;

  req_t bus_events_pending [$];
  rsp_t sequencer_outputs_due [$];
  int   queued;
  int   mismatches;
  logic req_taken;
  logic gaps_on;
  logic stalls_on;
  int   gap_left;
  int   burst_left;
  int   stall_left;

  function automatic void clear_message();
    phase_q    = PH_IDLE;
    dev_q      = '0;
    reg_q      = '0;
    hi_pend_q  = 1'b0;
    len_q      = '0;
    ptr_q      = '0;
    attempts_q = '0;
    nacks_q    = '0;
    foreach (store_q[i]) store_q[i] = 8'h00;
  endfunction

  function automatic rsp_t sequence_event(req_t r);
    rsp_t       o;
    logic [7:0] first;
    logic       failed;
    int         sum;
    o = '0;
    failed = 1'b0;
    first = hi_pend_q ? reg_q[15:8] : reg_q[7:0];
    case (r.req_type)
      REQ_START: begin
        dev_q      = r.dev_addr;
        reg_q      = r.reg_addr;
        hi_pend_q  = r.long_addr;
        len_q      = r.msg_len;
        phase_q    = r.is_read ? PH_AD_PEND : PH_WR_PEND;
        ptr_q      = '0;
        attempts_q = '0;
      end
      REQ_LOAD: store_q[r.buf_index] = r.data_byte;
      REQ_POLL: begin
        if (phase_q == PH_WR_PEND) begin
          if (!r.stop_pending && !r.bus_busy) begin
            sum = int'(len_q) + (hi_pend_q ? 2 : 1);
            o.command     = CMD_WRITE;
            o.target_addr = dev_q;
            o.byte_count  = (sum > 63) ? 6'd63 : 6'(sum);
            o.tx_valid    = 1'b1;
            o.tx_byte     = first;
            phase_q       = PH_WR_BUSY;
          end
        end else if (phase_q == PH_AD_PEND) begin
          if (!r.stop_pending && !r.bus_busy) begin
            o.command     = CMD_ADDR;
            o.target_addr = dev_q;
            o.byte_count  = hi_pend_q ? 6'd2 : 6'd1;
            o.tx_valid    = 1'b1;
            o.tx_byte     = first;
            phase_q       = PH_AD_BUSY;
          end else begin
            failed = 1'b1;
          end
        end else if (phase_q == PH_RD_PEND) begin
          if (!r.stop_pending) begin
            o.command     = CMD_READ;
            o.target_addr = dev_q;
            o.byte_count  = len_q;
            phase_q       = PH_RD_BUSY;
          end else begin
            failed = 1'b1;
          end
        end
        if (failed) begin
          attempts_q = attempts_q + 4'd1;
          if (attempts_q >= retry_limit_q) begin
            clear_message();
            o.aborted = 1'b1;
          end
        end
      end
      REQ_STOP: begin
        nacks_q = '0;
        if (phase_q == PH_WR_BUSY || phase_q == PH_RD_BUSY) begin
          phase_q = PH_IDLE;
        end else if (phase_q == PH_AD_BUSY) begin
          phase_q = PH_AD_PEND;
        end
      end
      REQ_ACCESS: begin
        if (r.nack) begin
          o.command     = CMD_STOP;
          o.target_addr = dev_q;
          nacks_q = nacks_q + 4'd1;
          if (nacks_q >= retry_limit_q) begin
            clear_message();
            o.aborted = 1'b1;
          end
        end else if (phase_q == PH_AD_BUSY) begin
          phase_q = PH_RD_PEND;
        end
      end
      REQ_TX: begin
        o.tx_valid = 1'b1;
        if (hi_pend_q) begin
          o.tx_byte = reg_q[7:0];
          hi_pend_q = 1'b0;
        end else begin
          o.tx_byte = store_q[ptr_q];
          ptr_q = ptr_q + 5'd1;
        end
      end
      REQ_RX: begin
        store_q[ptr_q] = r.data_byte;
        ptr_q = ptr_q + 5'd1;
        o.rx_valid = 1'b1;
        o.rx_byte  = r.data_byte;
      end
      default: ;
    endcase
    o.msg_state   = phase_q;
    o.buf_pos     = ptr_q;
    o.retry_count = attempts_q;
    o.nack_count  = nacks_q;
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < 50) begin
      $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  // request stimulus, unused fields carry random bits
  function automatic req_t random_req(logic [2:0] kind);
    logic [63:0] w;
    req_t        r;
    w = {$urandom, $urandom};
    r = w[$bits(req_t)-1:0];
    r.req_type = kind;
    return r;
  endfunction

  task automatic enqueue(req_t r);
    bus_events_pending.push_back(r);
    if (r.req_type != REQ_UNUSED) begin
      queued++;
    end
  endtask

  task automatic push_start(logic [9:0] dev, logic [15:0] ra, logic la, logic [5:0] len,
                            logic rd);
    req_t r;
    r = random_req(REQ_START);
    r.dev_addr  = dev;
    r.reg_addr  = ra;
    r.long_addr = la;
    r.msg_len   = len;
    r.is_read   = rd;
    enqueue(r);
  endtask

  task automatic push_load(logic [4:0] idx, logic [7:0] d);
    req_t r;
    r = random_req(REQ_LOAD);
    r.buf_index = idx;
    r.data_byte = d;
    enqueue(r);
  endtask

  task automatic push_poll(logic stp, logic bb);
    req_t r;
    r = random_req(REQ_POLL);
    r.stop_pending = stp;
    r.bus_busy     = bb;
    enqueue(r);
  endtask

  task automatic push_access(logic nk);
    req_t r;
    r = random_req(REQ_ACCESS);
    r.nack = nk;
    enqueue(r);
  endtask

  task automatic push_rx(logic [7:0] d);
    req_t r;
    r = random_req(REQ_RX);
    r.data_byte = d;
    enqueue(r);
  endtask

  task automatic push_event(logic [2:0] kind);
    enqueue(random_req(kind));
  endtask

  // mostly well-formed write and read messages, some noise
  task automatic add_random_traffic(int n);
    int          target;
    int          len;
    int          la;
    int          nbytes;
    logic [1:0]  v;
    target = queued + n;
    while (queued < target) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 6);
      la = $urandom_range(0, 1);
      nbytes = (len > 10) ? 10 : len;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          for (int i = 0; i < nbytes; i++) begin
            push_load(($urandom_range(0, 5) == 0) ? 5'($urandom) : 5'(i), 8'($urandom));
          end
          push_start(10'($urandom), 16'($urandom), la[0], 6'(len), 1'b0);
          if ($urandom_range(0, 3) == 0) begin
            v = 2'($urandom_range(1, 3));
            push_poll(v[1], v[0]);
          end
          push_poll(1'b0, 1'b0);
          repeat (la + 1 + nbytes) push_event(REQ_TX);
          push_access($urandom_range(0, 5) == 0);
          push_event(REQ_STOP);
        end
        4, 5, 6, 7: begin
          push_start(10'($urandom), 16'($urandom), la[0], 6'(len), 1'b1);
          if ($urandom_range(0, 3) == 0) begin
            v = 2'($urandom_range(1, 3));
            push_poll(v[1], v[0]);
          end
          push_poll(1'b0, 1'b0);
          repeat (la + 1) push_event(REQ_TX);
          push_access($urandom_range(0, 7) == 0);
          if ($urandom_range(0, 4) == 0) begin
            push_poll(1'b1, 1'($urandom));
          end
          push_poll(1'b0, 1'($urandom));
          repeat (nbytes) push_rx(8'($urandom));
          push_event(REQ_STOP);
        end
        default: begin
          repeat ($urandom_range(1, 4)) push_event(3'($urandom_range(0, 7)));
        end
      endcase
    end
  endtask

  task automatic drain();
    while (bus_events_pending.size() != 0 || push || sequencer_outputs_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_retry_limit(logic [3:0] v);
    drain();
    cfg_we_i      <= 1'b1;
    cfg_wdata_i   <= v;
    retry_limit_q  = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!push || req_taken) begin
        if (gap_left > 0) begin
          push <= 1'b0;
          gap_left--;
        end else if (bus_events_pending.size() != 0) begin
          push  <= 1'b1;
          req_i <= bus_events_pending.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            if (gaps_on) begin
              gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(1, 5);
            end
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        if (stalls_on && $urandom_range(0, 3) == 0) begin
          stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24)
                                                   : $urandom_range(1, 4);
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    rsp_t want;
    req_taken = rst_ni && push && !full;
    if (req_taken) begin
      sequencer_outputs_due.push_back(sequence_event(req_i));
    end
    if (rst_ni && pop && !empty) begin
      if (sequencer_outputs_due.size() == 0) begin
        report_mismatch("result with none due", 1, 0);
      end else begin
        want = sequencer_outputs_due.pop_front();
        if (rsp_o.msg_state !== want.msg_state)
          report_mismatch("msg_state", rsp_o.msg_state, want.msg_state);
        if (rsp_o.command !== want.command)
          report_mismatch("command", rsp_o.command, want.command);
        if (rsp_o.byte_count !== want.byte_count)
          report_mismatch("byte_count", rsp_o.byte_count, want.byte_count);
        if (rsp_o.target_addr !== want.target_addr)
          report_mismatch("target_addr", rsp_o.target_addr, want.target_addr);
        if (rsp_o.tx_valid !== want.tx_valid)
          report_mismatch("tx_valid", rsp_o.tx_valid, want.tx_valid);
        if (rsp_o.tx_byte !== want.tx_byte)
          report_mismatch("tx_byte", rsp_o.tx_byte, want.tx_byte);
        if (rsp_o.rx_valid !== want.rx_valid)
          report_mismatch("rx_valid", rsp_o.rx_valid, want.rx_valid);
        if (rsp_o.rx_byte !== want.rx_byte)
          report_mismatch("rx_byte", rsp_o.rx_byte, want.rx_byte);
        if (rsp_o.buf_pos !== want.buf_pos)
          report_mismatch("buf_pos", rsp_o.buf_pos, want.buf_pos);
        if (rsp_o.retry_count !== want.retry_count)
          report_mismatch("retry_count", rsp_o.retry_count, want.retry_count);
        if (rsp_o.nack_count !== want.nack_count)
          report_mismatch("nack_count", rsp_o.nack_count, want.nack_count);
        if (rsp_o.aborted !== want.aborted)
          report_mismatch("aborted", rsp_o.aborted, want.aborted);
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    push        = 1'b0;
    pop         = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 4'd0;
    req_i       = '0;
    req_taken   = 1'b0;
    gaps_on     = 1'b0;
    stalls_on   = 1'b0;
    gap_left    = 0;
    burst_left  = 0;
    stall_left  = 0;
    queued      = 0;
    mismatches  = 0;
    retry_limit_q = RETRY_LIMIT_RST;
    clear_message();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, retry limit at reset value
    push_event(REQ_UNUSED);
    push_load(5'd31, 8'hff);
    push_load(5'd0, 8'h00);
    push_start(10'h3ff, 16'hffff, 1'b1, 6'd63, 1'b0);
    push_poll(1'b1, 1'b0);
    push_poll(1'b0, 1'b1);
    push_poll(1'b0, 1'b0);
    push_event(REQ_TX);
    push_event(REQ_TX);
    push_access(1'b1);
    push_event(REQ_STOP);
    push_start(10'h000, 16'h0000, 1'b0, 6'd0, 1'b1);
    push_poll(1'b1, 1'b0);
    push_poll(1'b0, 1'b1);
    push_poll(1'b0, 1'b0);
    push_event(REQ_TX);
    push_access(1'b0);
    // new start replaces the message in flight
    push_start(10'h155, 16'h00a5, 1'b0, 6'd32, 1'b1);
    push_poll(1'b0, 1'b0);
    push_access(1'b0);
    push_poll(1'b0, 1'b1);
    push_rx(8'h00);
    push_rx(8'hff);
    push_event(REQ_STOP);
    repeat (3) push_access(1'b1);

    // random phases over several retry limits
    for (int i = 0; i < 5; i++) begin
      case (i)
        0: write_retry_limit(4'd15);
        1: write_retry_limit(4'd0);
        2: write_retry_limit(4'd1);
        3: write_retry_limit(4'd7);
        default: write_retry_limit(4'($urandom_range(2, 14)));
      endcase
      gaps_on   = (i != 2);
      stalls_on = (i != 1);
      add_random_traffic(120);
    end

    drain();
    if (sequencer_outputs_due.size() != 0) begin
      report_mismatch("results never seen", sequencer_outputs_due.size(), 0);
    end
    if (mismatches == 0) begin
      $display("i2c_register_transfer_sequencer regression: pass");
    end else begin
      $display("i2c_register_transfer_sequencer regression: fail");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("i2c_register_transfer_sequencer regression: fail");
    $finish;
  end

endmodule

FILE: i2c_register_transfer_sequencer.f
rtl/i2c_rts_pkg.sv
rtl/i2c_rts_front.sv
rtl/i2c_rts_back.sv
rtl/i2c_register_transfer_sequencer.sv
tb/sv/tb_i2c_register_transfer_sequencer.sv
